// ===== rtl/kscp_pkg.sv =====
`timescale 1ns / 1ps
// kscp_pkg: constants, codes and types of the keyframe spline camera player
// no dependencies; imported by keyframe_spline_camera_player
package kscp_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int NUM_ATTRS = 11;
    localparam int KEY_W     = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int KV_DEPTH  = MAX_KEYS * NUM_ATTRS;
    localparam int KV_AW     = $clog2(KV_DEPTH);
    localparam int ATTR_W    = 4;
    localparam int DIV_NW    = 49;
    localparam int SQRT_STEPS = 32;
    localparam int BLEND_BEATS = 4 * NUM_ATTRS;
    localparam int HOLD_ATTRS  = 8;
    localparam int ROT_FIRST   = 3;

    localparam logic [30:0] SPAN_RESET = 31'd196608;
    localparam logic signed [17:0] CTL_ONE = 18'sd65536;

    typedef enum logic [2:0] {
        ACT_STAGE  = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_TOGGLE = 3'd3,
        ACT_TICK   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_LAST   = 2'd1,
        ST_FIRST  = 2'd2
    } t_status;

    typedef enum logic {
        REG_SPAN   = 1'b0,
        REG_MANUAL = 1'b1
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_WR,
        S_TK_MUL,
        S_TK_LD,
        S_TK_DIV,
        S_TK_ADD,
        S_WK_RD,
        S_WK_CMP,
        S_HOLD,
        S_MU_DIV,
        S_SQ,
        S_CU,
        S_WGT,
        S_BLEND,
        S_NRM_SQ,
        S_SQRT,
        S_NRM_LD,
        S_NRM_DIV,
        S_NRM_ST,
        S_DONE
    } t_state;

endpackage

// ===== rtl/keyframe_spline_camera_player.sv =====
`timescale 1ns / 1ps
// keyframe_spline_camera_player: one camera track of keyframes with Catmull-Rom playback
// depends on kscp_pkg
//
// Commands arrive on start/busy: a beat is taken when start is high and busy low.
// action selects stage attribute, append keyframe, delete last, toggle play or tick.
// Stage, delete and toggle finish in the accepting cycle; busy stays low.
// Append copies the staged values into the value memory, one word a cycle.
// A tick while playing gives one result beat on o_valid, held for exactly one cycle;
// the receiver cannot hold it off. Other commands give no result.
// Tick: time is scaled through the shared 49-step divider, then the stamp memory
// is walked segment by segment. A held endpoint then reads out the key's values.
// A blend adds a divide for the time fraction, the 44 reads of the value memory
// over its single read port, the square root and four quaternion divides.
// One command is worked at a time.
// Configuration (i_cfg_we) writes the span and manual mode; write only while idle.
// Reset (synchronous, active low) empties the track, stops play and clears the
// staged values; keyframe memories need no clearing, the key count guards them.
module keyframe_spline_camera_player (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_action,
    input  logic [3:0]          i_attr_select,
    input  logic signed [31:0]  i_attr_value,
    input  logic [30:0]         i_dt,
    input  logic signed [17:0]  i_control,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [30:0]         i_cfg_wdata,
    output logic                o_valid,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic signed [31:0]  o_rot_x,
    output logic signed [31:0]  o_rot_y,
    output logic signed [31:0]  o_rot_z,
    output logic signed [31:0]  o_rot_w,
    output logic signed [31:0]  o_field_of_view,
    output logic signed [31:0]  o_focus_distance,
    output logic signed [31:0]  o_dof_scale,
    output logic signed [31:0]  o_dof_strength,
    output logic [1:0]          o_status
);
    import kscp_pkg::*;

    t_state r_state, n_state;

    logic [30:0]               r_span;
    logic                      r_manual;
    logic signed [31:0]        r_staged [NUM_ATTRS];
    logic [CNT_W-1:0]          r_count;
    logic                      r_playing;
    logic [31:0]               r_play_time;
    logic [KEY_W-1:0]          r_seg;

    logic [31:0]               r_kt_mem [MAX_KEYS];
    logic [31:0]               r_kv_mem [KV_DEPTH];
    logic [31:0]               r_kt_q0, r_kt_q1;
    logic signed [31:0]        r_kv_q;

    logic                      kt_we;
    logic [KEY_W-1:0]          kt_wa, kt_ra0, kt_ra1;
    logic [31:0]               kt_wd;
    logic                      kv_we;
    logic [KV_AW-1:0]          kv_wa, kv_ra;
    logic [31:0]               kv_wd;

    logic [30:0]               r_dt;
    logic signed [17:0]        r_ctl;
    logic signed [48:0]        r_prod;
    logic                      r_neg;
    logic [48:0]               r_dnum;
    logic [31:0]               r_drem, r_dden;
    logic [5:0]                r_dcnt;
    logic signed [32:0]        r_t;
    logic [KEY_W-1:0]          r_src;
    t_status                   r_status;
    logic [5:0]                r_cnt;
    logic [KEY_W-1:0]          r_k [4];
    logic [15:0]               r_s, r_s2, r_s3;
    logic signed [19:0]        r_w [4];
    logic                      r_p1_v, r_p2_v;
    logic [1:0]                r_p1_tap, r_p2_tap;
    logic [ATTR_W-1:0]         r_p1_attr, r_p2_attr;
    logic signed [51:0]        r_mp;
    logic signed [55:0]        r_acc;
    logic signed [31:0]        r_res [NUM_ATTRS];
    logic [63:0]               r_n2;
    logic [63:0]               r_sq_n;
    logic [32:0]               r_sq_rem;
    logic [31:0]               r_root;

    // divider step
    logic [32:0]               d_sh;
    logic                      d_ge;
    logic [32:0]               d_diff;
    // sqrt step
    logic [33:0]               q_cur, q_trial, q_diff;
    logic                      q_ge;
    // tick arithmetic
    logic signed [48:0]        abs_prod;
    logic signed [50:0]        t_sum;
    logic [32:0]               app_sum;
    // walk
    logic signed [32:0]        t_lo, t_hi;
    logic                      can_fwd;
    logic [31:0]               mu_diff, mu_den;
    // weights and blend
    logic [31:0]               sq_ss, sq_s2s;
    logic signed [19:0]        e_s, e_s2, e_s3;
    logic signed [51:0]        mul_bl;
    logic signed [55:0]        bl_sum, bl_rnd;
    logic signed [31:0]        bl_sat;
    logic                      bl_rot;
    // normalization
    logic [ATTR_W-1:0]         rot_idx;
    logic signed [63:0]        rot_sq;
    logic [30:0]               rot_mag;

    function automatic logic [KV_AW-1:0] kv_addr(input logic [KEY_W-1:0] k,
                                                 input logic [ATTR_W-1:0] a);
        kv_addr = KV_AW'(k * NUM_ATTRS) + KV_AW'(a);
    endfunction

    always_comb begin
        d_sh   = {r_drem, r_dnum[48]};
        d_ge   = d_sh >= {1'b0, r_dden};
        d_diff = d_sh - {1'b0, r_dden};

        q_cur   = {r_sq_rem[31:0], r_sq_n[63:62]};
        q_trial = {r_root, 2'b01};
        q_ge    = q_cur >= q_trial;
        q_diff  = q_cur - q_trial;

        abs_prod = r_prod[48] ? -r_prod : r_prod;
        t_sum    = $signed({19'b0, r_play_time}) +
                   (r_neg ? -$signed({2'b0, r_dnum}) : $signed({2'b0, r_dnum}));
        app_sum  = {1'b0, r_kt_q0} + {2'b0, r_span};

        t_lo    = $signed({1'b0, r_kt_q0});
        t_hi    = $signed({1'b0, r_kt_q1});
        can_fwd = ({1'b0, r_seg} + CNT_W'(2)) < r_count;
        mu_diff = r_t[31:0] - r_kt_q0;
        mu_den  = r_kt_q1 - r_kt_q0;

        sq_ss  = r_s * r_s;
        sq_s2s = r_s2 * r_s;
        e_s    = $signed({4'b0, r_s});
        e_s2   = $signed({4'b0, r_s2});
        e_s3   = $signed({4'b0, r_s3});

        mul_bl = r_kv_q * r_w[r_p1_tap];
        bl_sum = (r_p2_tap == 2'd0 ? 56'sd0 : r_acc) + 56'(r_mp);
        bl_rnd = (bl_sum + 56'sd65536) >>> 17;
        bl_rot = (r_p2_attr >= ATTR_W'(ROT_FIRST)) && (r_p2_attr < ATTR_W'(ROT_FIRST + 4));
        if (bl_rnd > 56'sd2147483647) begin
            bl_sat = 32'sh7FFFFFFF;
        end else if (bl_rnd < -56'sd2147483647) begin
            bl_sat = bl_rot ? -32'sh7FFFFFFF : 32'sh80000000;
        end else begin
            bl_sat = bl_rnd[31:0];
        end

        rot_idx = ATTR_W'(ROT_FIRST) + {2'b0, r_cnt[1:0]};
        rot_sq  = r_res[rot_idx] * r_res[rot_idx];
        rot_mag = r_res[rot_idx][31] ? 31'(-r_res[rot_idx]) : r_res[rot_idx][30:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_action == ACT_APPEND && !r_playing &&
                        r_count < CNT_W'(MAX_KEYS)) begin
                        n_state = S_APP_RD;
                    end else if (i_action == ACT_TICK && r_playing &&
                                 r_count >= CNT_W'(2)) begin
                        n_state = S_TK_MUL;
                    end
                end
            end
            S_APP_RD:  n_state = S_APP_WR;
            S_APP_WR:  if (r_cnt == 6'(NUM_ATTRS - 1)) n_state = S_IDLE;
            S_TK_MUL:  n_state = S_TK_LD;
            S_TK_LD:   n_state = S_TK_DIV;
            S_TK_DIV:  if (r_dcnt == 6'd1) n_state = S_TK_ADD;
            S_TK_ADD:  n_state = S_WK_RD;
            S_WK_RD:   n_state = S_WK_CMP;
            S_WK_CMP: begin
                if (r_t >= t_hi) begin
                    n_state = can_fwd ? S_WK_RD : S_HOLD;
                end else if (r_t < t_lo) begin
                    n_state = (r_seg != '0) ? S_WK_RD : S_HOLD;
                end else begin
                    n_state = S_MU_DIV;
                end
            end
            S_HOLD:    if (r_cnt == 6'(HOLD_ATTRS)) n_state = S_DONE;
            S_MU_DIV:  if (r_dcnt == 6'd1) n_state = S_SQ;
            S_SQ:      n_state = S_CU;
            S_CU:      n_state = S_WGT;
            S_WGT:     n_state = S_BLEND;
            S_BLEND: begin
                if (r_cnt == 6'(BLEND_BEATS) && !r_p1_v && !r_p2_v) n_state = S_NRM_SQ;
            end
            S_NRM_SQ:  if (r_cnt == 6'd3) n_state = S_SQRT;
            S_SQRT:    if (r_dcnt == 6'd1) n_state = S_NRM_LD;
            S_NRM_LD:  n_state = (r_root == '0) ? S_DONE : S_NRM_DIV;
            S_NRM_DIV: if (r_dcnt == 6'd1) n_state = S_NRM_ST;
            S_NRM_ST:  n_state = (r_cnt == 6'd3) ? S_DONE : S_NRM_LD;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs and memory ports
    always_comb begin
        busy    = r_state != S_IDLE;
        o_valid = r_state == S_DONE;
        kt_we   = 1'b0;
        kt_wa   = r_count[KEY_W-1:0];
        kt_wd   = (r_count == '0) ? 32'd0 : (app_sum[32] ? 32'hFFFFFFFF : app_sum[31:0]);
        kt_ra0  = r_seg;
        kt_ra1  = r_seg + KEY_W'(1);
        kv_we   = 1'b0;
        kv_wa   = kv_addr(r_count[KEY_W-1:0], r_cnt[3:0]);
        kv_wd   = r_staged[r_cnt[3:0]];
        kv_ra   = kv_addr(r_src, r_cnt[3:0]);
        case (r_state)
            S_APP_RD: kt_ra0 = KEY_W'(r_count - CNT_W'(1));
            S_APP_WR: begin
                kv_we = 1'b1;
                kt_we = r_cnt == '0;
            end
            S_BLEND:  kv_ra = kv_addr(r_k[r_cnt[1:0]], r_cnt[5:2]);
            default:  kv_we = 1'b0;
        endcase
    end

    assign o_pos_x          = r_res[0];
    assign o_pos_y          = r_res[1];
    assign o_pos_z          = r_res[2];
    assign o_rot_x          = r_res[3];
    assign o_rot_y          = r_res[4];
    assign o_rot_z          = r_res[5];
    assign o_rot_w          = r_res[6];
    assign o_field_of_view  = r_res[7];
    assign o_focus_distance = r_res[8];
    assign o_dof_scale      = r_res[9];
    assign o_dof_strength   = r_res[10];
    assign o_status         = r_status;

    always_ff @(posedge i_clk) begin
        if (kt_we) begin
            r_kt_mem[kt_wa] <= kt_wd;
        end
        r_kt_q0 <= r_kt_mem[kt_ra0];
        r_kt_q1 <= r_kt_mem[kt_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            r_kv_mem[kv_wa] <= kv_wd;
        end
        r_kv_q <= r_kv_mem[kv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_span    <= SPAN_RESET;
            r_manual  <= 1'b0;
            for (int i = 0; i < NUM_ATTRS; i++) begin
                r_staged[i] <= '0;
            end
            r_count     <= '0;
            r_playing   <= 1'b0;
            r_play_time <= '0;
            r_seg       <= '0;
            r_cnt       <= '0;
            r_dcnt      <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SPAN) begin
                    r_span <= i_cfg_wdata;
                end else begin
                    r_manual <= i_cfg_wdata[0];
                end
            end
            r_p1_v <= (r_state == S_BLEND) && (r_cnt != 6'(BLEND_BEATS));
            r_p2_v <= r_p1_v;
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (start) begin
                        case (i_action)
                            ACT_STAGE: begin
                                if (i_attr_select < ATTR_W'(NUM_ATTRS)) begin
                                    r_staged[i_attr_select] <= i_attr_value;
                                end
                            end
                            ACT_DELETE: begin
                                if (!r_playing && r_count != '0) begin
                                    r_count <= r_count - CNT_W'(1);
                                end
                            end
                            ACT_TOGGLE: begin
                                if (r_count > CNT_W'(1)) begin
                                    r_playing <= !r_playing;
                                    if (!r_playing) begin
                                        r_play_time <= '0;
                                        r_seg       <= '0;
                                    end
                                end
                            end
                            default: begin
                                r_dt  <= i_dt;
                                r_ctl <= r_manual ? i_control : CTL_ONE;
                            end
                        endcase
                    end
                end
                S_APP_WR: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(NUM_ATTRS - 1)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                S_TK_MUL: r_prod <= $signed({1'b0, r_dt}) * r_ctl;
                S_TK_LD: begin
                    r_neg  <= r_prod[48];
                    r_dnum <= abs_prod;
                    r_drem <= '0;
                    r_dden <= (r_span == '0) ? 32'd1 : {1'b0, r_span};
                    r_dcnt <= 6'(DIV_NW);
                end
                S_TK_DIV, S_MU_DIV, S_NRM_DIV: begin
                    r_dnum <= {r_dnum[47:0], d_ge};
                    r_drem <= d_ge ? d_diff[31:0] : d_sh[31:0];
                    r_dcnt <= r_dcnt - 6'd1;
                end
                S_TK_ADD: begin
                    if (t_sum > 51'sh0FFFFFFFF) begin
                        r_t <= 33'sh0FFFFFFFF;
                    end else if (t_sum < 51'sd0) begin
                        r_t <= -33'sd1;
                    end else begin
                        r_t <= t_sum[32:0];
                    end
                    if ({1'b0, r_seg} > r_count - CNT_W'(2)) begin
                        r_seg <= KEY_W'(r_count - CNT_W'(2));
                    end
                end
                S_WK_CMP: begin
                    r_cnt <= '0;
                    if (r_t >= t_hi) begin
                        if (can_fwd) begin
                            r_seg <= r_seg + KEY_W'(1);
                        end else begin
                            r_src       <= r_seg + KEY_W'(1);
                            r_status    <= ST_LAST;
                            r_play_time <= r_t[31:0];
                        end
                    end else if (r_t < t_lo) begin
                        if (r_seg != '0) begin
                            r_seg <= r_seg - KEY_W'(1);
                        end else begin
                            r_src       <= '0;
                            r_status    <= ST_FIRST;
                            r_play_time <= '0;
                        end
                    end else begin
                        r_status    <= ST_INTERP;
                        r_play_time <= r_t[31:0];
                        r_k[0] <= (r_seg != '0) ? r_seg - KEY_W'(1) : r_seg;
                        r_k[1] <= r_seg;
                        r_k[2] <= r_seg + KEY_W'(1);
                        r_k[3] <= can_fwd ? r_seg + KEY_W'(2) : r_seg + KEY_W'(1);
                        r_dnum <= {1'b0, mu_diff, 16'b0};
                        r_drem <= '0;
                        r_dden <= mu_den;
                        r_dcnt <= 6'(DIV_NW);
                    end
                end
                S_HOLD: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt != '0) begin
                        r_res[r_cnt[3:0] - 4'd1] <= r_kv_q;
                    end
                    if (r_cnt == 6'(HOLD_ATTRS)) begin
                        r_res[8]  <= '0;
                        r_res[9]  <= '0;
                        r_res[10] <= '0;
                    end
                end
                S_SQ:  r_s2 <= sq_ss[31:16];
                S_CU:  r_s3 <= sq_s2s[31:16];
                S_WGT: begin
                    r_w[0] <= -e_s3 + (e_s2 <<< 1) - e_s;
                    r_w[1] <= 20'sd3 * e_s3 - 20'sd5 * e_s2 + 20'sd131072;
                    r_w[2] <= -(20'sd3 * e_s3) + (e_s2 <<< 2) + e_s;
                    r_w[3] <= e_s3 - e_s2;
                    r_cnt  <= '0;
                    r_n2   <= '0;
                end
                S_BLEND: begin
                    if (r_cnt != 6'(BLEND_BEATS)) begin
                        r_cnt     <= r_cnt + 6'd1;
                        r_p1_tap  <= r_cnt[1:0];
                        r_p1_attr <= r_cnt[5:2];
                    end
                    r_mp      <= mul_bl;
                    r_p2_tap  <= r_p1_tap;
                    r_p2_attr <= r_p1_attr;
                    if (r_p2_v) begin
                        r_acc <= bl_sum;
                        if (r_p2_tap == 2'd3) begin
                            r_res[r_p2_attr] <= bl_sat;
                        end
                    end
                    if (n_state == S_NRM_SQ) begin
                        r_cnt <= '0;
                    end
                end
                S_NRM_SQ: begin
                    r_n2 <= r_n2 + 64'(rot_sq);
                    if (r_cnt == 6'd3) begin
                        r_sq_n   <= r_n2 + 64'(rot_sq);
                        r_sq_rem <= '0;
                        r_root   <= '0;
                        r_dcnt   <= 6'(SQRT_STEPS);
                        r_cnt    <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SQRT: begin
                    r_sq_n   <= {r_sq_n[61:0], 2'b00};
                    r_sq_rem <= q_ge ? q_diff[32:0] : q_cur[32:0];
                    r_root   <= {r_root[30:0], q_ge};
                    r_dcnt   <= r_dcnt - 6'd1;
                end
                S_NRM_LD: begin
                    if (r_root == '0) begin
                        for (int i = ROT_FIRST; i < ROT_FIRST + 4; i++) begin
                            r_res[i] <= '0;
                        end
                    end else begin
                        r_neg  <= r_res[rot_idx][31];
                        r_dnum <= 49'({rot_mag, 16'b0}) + 49'(r_root[31:1]);
                        r_drem <= '0;
                        r_dden <= r_root;
                        r_dcnt <= 6'(DIV_NW);
                    end
                end
                S_NRM_ST: begin
                    r_res[rot_idx] <= r_neg ? -$signed(r_dnum[31:0]) : $signed(r_dnum[31:0]);
                    r_cnt <= r_cnt + 6'd1;
                end
                default: r_cnt <= r_cnt;
            endcase
            if (r_state == S_MU_DIV && r_dcnt == 6'd1) begin
                r_s <= r_dnum[47:32] == '0 ? {r_dnum[14:0], d_ge} : 16'hFFFF;
            end
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("key count above capacity");

    a_play_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> r_count >= CNT_W'(2))
        else $error("playing with fewer than two keys");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_playing && r_state == S_IDLE) |-> ({1'b0, r_seg} + CNT_W'(2) <= r_count))
        else $error("segment index past last segment");

    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("result beat not followed by idle");

    a_held_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_INTERP) |->
        (o_focus_distance == '0 && o_dof_scale == '0 && o_dof_strength == '0))
        else $error("held endpoint with nonzero focus or dof");

endmodule

// ===== sim/keyframe_spline_camera_player_tb.sv =====
`timescale 1ns / 1ps
// keyframe_spline_camera_player_tb: self-checking bench for the camera track player
// a scoreboard class predicts every tick frame; plain tasks drive commands and registers
// depends on kscp_pkg and keyframe_spline_camera_player
module keyframe_spline_camera_player_tb;
    import kscp_pkg::*;

    typedef struct packed {
        logic [2:0]         act;
        logic [3:0]         sel;
        logic signed [31:0] val;
        logic [30:0]        dt;
        logic signed [17:0] ctl;
    } cmd_t;

    typedef struct {
        logic [31:0] f [NUM_ATTRS];
        logic [1:0]  st;
    } frame_t;

    class camera_track_scoreboard;
        logic [31:0]        stamps [MAX_KEYS];
        logic signed [31:0] keyvals [MAX_KEYS][NUM_ATTRS];
        logic signed [31:0] staged [NUM_ATTRS];
        int                 count;
        logic [31:0]        ptime;
        int                 seg;
        bit                 playing;
        logic [30:0]        span;
        bit                 manual;
        frame_t             pending_frames [$];
        int                 errors;
        int                 frames_seen;
        int                 n_held_first, n_held_last, n_interp;

        function new();
            count = 0; ptime = 0; seg = 0; playing = 0;
            span = SPAN_RESET; manual = 0; errors = 0; frames_seen = 0;
            n_held_first = 0; n_held_last = 0; n_interp = 0;
            foreach (staged[i]) staged[i] = 0;
        endfunction

        function void write_reg(t_reg idx, logic [30:0] data);
            if (idx == REG_SPAN) span = data;
            else manual = data[0];
        endfunction

        function int pending();
            return pending_frames.size();
        endfunction

        function automatic logic [63:0] isqrt(logic [63:0] n);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void play_tick(logic [30:0] dt, logic signed [17:0] ctl);
            longint spn, c, prod, q, t, s, s2, s3, acc, num, den;
            longint w [4];
            longint res [NUM_ATTRS];
            logic [63:0] n2, r, mag;
            int held, src, k0, k1, k2, k3;
            frame_t fr;
            spn = (span == 0) ? 1 : longint'(span);
            c = manual ? longint'(ctl) : 65536;
            prod = longint'(dt) * c;
            q = (prod < 0 ? -prod : prod) / spn;
            t = longint'(ptime) + (prod < 0 ? -q : q);
            held = 0;
            src = 0;
            if (t > 64'sh0FFFFFFFF) t = 64'sh0FFFFFFFF;
            if (seg > count - 2) seg = count - 2;
            forever begin
                if (t >= longint'(stamps[seg + 1])) begin
                    if (seg + 1 < count - 1) seg++;
                    else begin
                        held = ST_LAST; src = seg + 1; break;
                    end
                end else if (t < longint'(stamps[seg])) begin
                    if (seg > 0) seg--;
                    else begin
                        t = 0; held = ST_FIRST; src = 0; break;
                    end
                end else break;
            end
            ptime = t[31:0];
            if (held != 0) begin
                for (int i = 0; i < NUM_ATTRS; i++)
                    fr.f[i] = (i < HOLD_ATTRS) ? keyvals[src][i] : 32'd0;
                fr.st = held[1:0];
                if (held == ST_LAST) n_held_last++; else n_held_first++;
                pending_frames = {pending_frames, fr};
                return;
            end
            k1 = seg;
            k2 = seg + 1;
            k0 = seg > 0 ? seg - 1 : seg;
            k3 = (k2 < count - 1) ? k2 + 1 : k2;
            num = (t - longint'(stamps[k1])) <<< 16;
            den = longint'(stamps[k2]) - longint'(stamps[k1]);
            s = num / den;
            s2 = (s * s) >>> 16;
            s3 = (s2 * s) >>> 16;
            w[0] = -s3 + 2 * s2 - s;
            w[1] = 3 * s3 - 5 * s2 + 2 * 65536;
            w[2] = -3 * s3 + 4 * s2 + s;
            w[3] = s3 - s2;
            for (int i = 0; i < NUM_ATTRS; i++) begin
                acc = longint'(keyvals[k0][i]) * w[0] + longint'(keyvals[k1][i]) * w[1]
                    + longint'(keyvals[k2][i]) * w[2] + longint'(keyvals[k3][i]) * w[3];
                res[i] = clamp((acc + 65536) >>> 17, -64'sd2147483648, 64'sd2147483647);
            end
            n2 = 0;
            for (int i = ROT_FIRST; i < ROT_FIRST + 4; i++) begin
                res[i] = clamp(res[i], -64'sd2147483647, 64'sd2147483647);
                n2 = n2 + 64'(res[i] * res[i]);
            end
            r = isqrt(n2);
            for (int i = ROT_FIRST; i < ROT_FIRST + 4; i++) begin
                if (r == 0) res[i] = 0;
                else begin
                    mag = 64'(res[i] < 0 ? -res[i] : res[i]);
                    mag = ((mag << 16) + r / 2) / r;
                    res[i] = res[i] < 0 ? -longint'(mag) : longint'(mag);
                end
            end
            for (int i = 0; i < NUM_ATTRS; i++) fr.f[i] = res[i][31:0];
            fr.st = ST_INTERP;
            n_interp++;
            pending_frames = {pending_frames, fr};
        endfunction

        function void note_command(cmd_t c);
            logic [63:0] nt;
            case (c.act)
                ACT_STAGE: begin
                    if (c.sel < NUM_ATTRS) staged[c.sel] = c.val;
                end
                ACT_APPEND: begin
                    if (!playing && count < MAX_KEYS) begin
                        if (count == 0) stamps[0] = 0;
                        else begin
                            nt = 64'(stamps[count - 1]) + 64'(span);
                            stamps[count] = nt > 64'hFFFFFFFF ? 32'hFFFFFFFF : nt[31:0];
                        end
                        for (int i = 0; i < NUM_ATTRS; i++) keyvals[count][i] = staged[i];
                        count++;
                    end
                end
                ACT_DELETE: begin
                    if (!playing && count > 0) count--;
                end
                ACT_TOGGLE: begin
                    if (count > 1) begin
                        playing = !playing;
                        if (playing) begin
                            ptime = 0; seg = 0;
                        end
                    end
                end
                ACT_TICK: begin
                    if (playing && count >= 2) play_tick(c.dt, c.ctl);
                end
                default: ;
            endcase
        endfunction

        function void check_frame(frame_t act);
            frame_t e;
            string names [NUM_ATTRS] = '{"pos_x", "pos_y", "pos_z", "rot_x", "rot_y",
                "rot_z", "rot_w", "field_of_view", "focus_distance", "dof_scale",
                "dof_strength"};
            frames_seen++;
            if (pending_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, status %0d", $time, act.st);
                return;
            end
            e = pending_frames.pop_front();
            for (int i = 0; i < NUM_ATTRS; i++)
                if (act.f[i] !== e.f[i]) begin
                    errors++;
                    $display("%0t: %s expected %h actual %h", $time, names[i], e.f[i],
                             act.f[i]);
                end
            if (act.st !== e.st) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.st, act.st);
            end
        endfunction
    endclass

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT = 50000;
    localparam int SETTLE_CYCLES = 600;
    localparam int N_ITEMS = 1950;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_action = '0;
    logic [3:0]         i_attr_select = '0;
    logic signed [31:0] i_attr_value = '0;
    logic [30:0]        i_dt = '0;
    logic signed [17:0] i_control = '0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = 1'b0;
    logic [30:0]        i_cfg_wdata = '0;
    logic               o_valid;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z, o_rot_x, o_rot_y, o_rot_z, o_rot_w;
    logic signed [31:0] o_field_of_view, o_focus_distance, o_dof_scale, o_dof_strength;
    logic [1:0]         o_status;

    camera_track_scoreboard track_sb = new();
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  burst_mode = 0;

    always #5 i_clk = ~i_clk;

    keyframe_spline_camera_player i_dut (.*);

    always @(posedge i_clk) begin
        frame_t fr;
        if (i_rst_n && o_valid) begin
            fr.f = '{o_pos_x, o_pos_y, o_pos_z, o_rot_x, o_rot_y, o_rot_z, o_rot_w,
                     o_field_of_view, o_focus_distance, o_dof_scale, o_dof_strength};
            fr.st = o_status;
            track_sb.check_frame(fr);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     track_sb.pending());
            $display("** keyframe_spline_camera_player: FAILED **");
            $finish;
        end
    end

    task automatic send(cmd_t c);
        @(negedge i_clk);
        start = 1'b1;
        i_action = c.act;
        i_attr_select = c.sel;
        i_attr_value = c.val;
        i_dt = c.dt;
        i_control = c.ctl;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        track_sb.note_command(c);
        items_sent++;
    endtask

    task automatic idle_gap();
        int n, k;
        k = $urandom_range(0, 99);
        if (burst_mode || k < 50) n = 0;
        else if (k < 90) n = $urandom_range(1, 3);
        else if (k < 99) n = $urandom_range(4, 20);
        else n = $urandom_range(100, 400);
        if (n > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic issue(logic [2:0] act, logic [3:0] sel, logic signed [31:0] val,
                         logic [30:0] dt, logic signed [17:0] ctl);
        cmd_t c;
        c.act = act; c.sel = sel; c.val = val; c.dt = dt; c.ctl = ctl;
        send(c);
        idle_gap();
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (track_sb.pending() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [30:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        track_sb.write_reg(idx, data);
    endtask

    function automatic logic signed [31:0] rand_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return $urandom();
        if (k < 8) return $signed($urandom_range(0, 131072)) - 65536;
        if (k == 8) return 32'sh80000000;
        return 32'sh7FFFFFFF;
    endfunction

    function automatic logic [30:0] rand_dt();
        longint tgt;
        int k;
        tgt = (longint'(track_sb.span) * longint'(track_sb.span)) / 131072;
        if (tgt > 64'sh3FFFFFFF) tgt = 64'sh3FFFFFFF;
        k = $urandom_range(0, 19);
        if (k == 0) return 0;
        if (k == 1) return 31'h7FFFFFFF;
        if (k == 2) return 31'($urandom());
        return 31'($urandom_range(0, 32'(2 * tgt + 1)));
    endfunction

    function automatic logic signed [17:0] rand_ctl();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return -18'sd65536;
        if (k == 1) return 18'sd65536;
        if (k < 4) return 18'sd0 - 18'($urandom_range(0, 65536));
        return 18'($urandom_range(0, 65536));
    endfunction

    task automatic noise();
        case ($urandom_range(0, 4))
            0: issue(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), 4'($urandom()),
                     $urandom(), 31'($urandom()), rand_ctl());
            1: issue(ACT_STAGE, 4'($urandom_range(NUM_ATTRS, 15)), $urandom(), 0, 0);
            2: issue(ACT_TICK, 4'($urandom()), $urandom(), rand_dt(), rand_ctl());
            3: issue(ACT_APPEND, 0, 0, 0, 0);
            default: issue(ACT_DELETE, 0, 0, 0, 0);
        endcase
    endtask

    // one track: build keys, play a while, stop, clear, with noise commands mixed in
    task automatic track_run();
        int nkeys, nticks, k;
        bit zero_rot;
        k = $urandom_range(0, 99);
        if (k < 88) nkeys = $urandom_range(2, 6);
        else if (k < 94) nkeys = $urandom_range(0, 1);
        else nkeys = $urandom_range(7, MAX_KEYS + 2);
        burst_mode = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < nkeys; n++) begin
            zero_rot = ($urandom_range(0, 15) == 0);
            for (int a = 0; a < NUM_ATTRS; a++)
                if (zero_rot && a >= ROT_FIRST && a < ROT_FIRST + 4)
                    issue(ACT_STAGE, 4'(a), 0, 0, 0);
                else if (nkeys < 10 || $urandom_range(0, 3) == 0)
                    issue(ACT_STAGE, 4'(a), rand_value(), 31'($urandom()), 0);
            issue(ACT_APPEND, 4'($urandom()), $urandom(), 0, 0);
            if ($urandom_range(0, 19) == 0) noise();
        end
        issue(ACT_TOGGLE, 0, 0, 0, 0);
        nticks = $urandom_range(3, 18);
        for (int n = 0; n < nticks; n++) begin
            issue(ACT_TICK, 4'($urandom()), $urandom(), rand_dt(), rand_ctl());
            if ($urandom_range(0, 14) == 0) noise();
        end
        if (track_sb.playing) issue(ACT_TOGGLE, 0, 0, 0, 0);
        for (int n = track_sb.count + $urandom_range(0, 1); n > 0; n--)
            issue(ACT_DELETE, 0, 0, 0, 0);
        burst_mode = 0;
    endtask

    initial begin
        logic [30:0] spans [6];
        bit          modes [6];
        int          quota;
        spans = '{SPAN_RESET, 31'd1, 31'h7FFFFFFF, 31'd65536, 31'd0, 31'd20000};
        modes = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        spans[4] = 31'($urandom_range(2, 1000000));
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty track, spare actions, bad selectors, field extremes
        burst_mode = 1;
        issue(ACT_DELETE, 0, 0, 0, 0);
        issue(ACT_TOGGLE, 0, 0, 0, 0);
        issue(ACT_TICK, 0, 0, 31'h7FFFFFFF, 18'sd65536);
        issue(ACT_SPARE_LO, 4'hF, 32'hFFFFFFFF, 31'h7FFFFFFF, -18'sd65536);
        issue(ACT_SPARE_HI, 0, 0, 0, 0);
        issue(ACT_STAGE, 4'd15, 32'h7FFFFFFF, 0, 0);
        for (int a = 0; a < NUM_ATTRS; a++)
            issue(ACT_STAGE, 4'(a), (a % 2) ? 32'sh80000000 : 32'sh7FFFFFFF, 0, 0);
        issue(ACT_APPEND, 0, 0, 0, 0);
        issue(ACT_TOGGLE, 0, 0, 0, 0);
        issue(ACT_STAGE, 4'd6, 32'sd65536, 0, 0);
        issue(ACT_APPEND, 0, 0, 0, 0);
        issue(ACT_TOGGLE, 0, 0, 0, 0);
        issue(ACT_APPEND, 0, 0, 0, 0);
        issue(ACT_DELETE, 0, 0, 0, 0);
        issue(ACT_TICK, 0, 0, 31'd0, 0);
        issue(ACT_TICK, 0, 0, 31'd98304, 0);
        issue(ACT_TICK, 0, 0, 31'h7FFFFFFF, 0);
        issue(ACT_TOGGLE, 0, 0, 0, 0);
        burst_mode = 0;
        drain();

        // several register settings; sender pauses for all results before each
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_SPAN, spans[p]);
            write_reg(REG_MANUAL, 31'(modes[p]));
            quota = items_sent + (N_ITEMS - 30) / 6;
            while (items_sent < quota) track_run();
            drain();
        end
        write_reg(REG_SPAN, SPAN_RESET);
        write_reg(REG_MANUAL, 31'd0);

        $display("sent %0d commands over 6 register settings; %0d frames checked",
                 items_sent, track_sb.frames_seen);
        $display("frames: %0d blended, %0d held at last key, %0d held at first key",
                 track_sb.n_interp, track_sb.n_held_last, track_sb.n_held_first);
        if (track_sb.errors == 0 && track_sb.pending() == 0)
            $display("** keyframe_spline_camera_player: PASSED **");
        else
            $display("** keyframe_spline_camera_player: FAILED **");
        $finish;
    end
endmodule
